@@ rtl/core/tsqm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsqm_pkg
// Types, codes and helpers shared by the TM SDU queue matcher modules.
// ----------------------------------------------------------------------------
package tsqm_pkg;

  localparam int QUEUE_DEPTH     = 16;
  localparam int SLOT_DELTA      = 2;
  localparam int SLOTS_PER_FRAME = 10;
  localparam int TICK_WRAP       = 10240;
  localparam int MAX_AGE_RESET   = 40;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // item kinds
  localparam logic [1:0] KIND_ENQUEUE  = 2'd0;
  localparam logic [1:0] KIND_TRANSMIT = 2'd1;
  localparam logic [1:0] KIND_FLUSH    = 2'd2;

  // result kinds
  localparam logic [2:0] RK_OCCUPANCY  = 3'd0;
  localparam logic [2:0] RK_DROPPED    = 3'd1;
  localparam logic [2:0] RK_SENT       = 3'd2;
  localparam logic [2:0] RK_NOT_FOUND  = 3'd3;
  localparam logic [2:0] RK_FULL       = 3'd4;
  localparam logic [2:0] RK_FLUSH_DONE = 3'd5;

  // config register indexes
  localparam int         CFG_IDX_W        = 1;
  localparam int         CFG_DATA_W       = 14;
  localparam logic [0:0] CFG_CHANNEL_KIND = 1'd0;
  localparam logic [0:0] CFG_MAX_AGE      = 1'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sdu_handle;
    logic [14:0] sdu_size;
    logic [9:0]  sched_sfn;
    logic [3:0]  sched_slot;
    logic [15:0] rnti;
    logic [17:0] trans_id;
    logic [13:0] current_time;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] out_handle;
    logic [14:0] out_size;
    logic [9:0]  out_sfn;
    logic [3:0]  out_slot;
    logic [15:0] out_rnti;
    logic [31:0] bytes_sent_total;
    logic [31:0] pdus_sent_total;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [14:0] size;
    logic [9:0]  sfn;
    logic [3:0]  slot;
    logic [15:0] user;
    logic [13:0] arrival;
  } entry_t;

  typedef enum logic [1:0] {
    ACT_KEEP,
    ACT_DROP,
    ACT_SEND
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WALK,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic load;       // capture input beat
    logic enq;        // store entry / refuse, emit report
    logic prep;       // latch match target, restart walk
    logic step;       // handle entry at walk index
    logic tail_emit;  // emit not-found or flush-done
    logic finish;     // commit compacted count
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       walk_done;
    act_t       action;
    logic       sent;
    logic       out_free;
  } status_t;

  // v mod 10 for v < 1029: quotient by reciprocal 205/2048
  function automatic logic [3:0] mod_slots(input logic [8:0] v);
    logic [16:0] p;
    logic [9:0]  q10;
    logic [9:0]  r;
    p   = 17'(v) * 17'd205;
    q10 = 10'(p[16:11]) * 10'(SLOTS_PER_FRAME);
    r   = 10'(v) - q10;
    return r[3:0];
  endfunction

  function automatic logic [13:0] norm_tick(input logic [13:0] t);
    return (t >= 14'(TICK_WRAP)) ? t - 14'(TICK_WRAP) : t;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/tsqm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsqm_ctrl
// Sequencer: dispatches an input beat and paces the queue walk.
// ----------------------------------------------------------------------------
module tsqm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire tsqm_pkg::status_t status,
  output tsqm_pkg::cmd_t         cmd
);

  tsqm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsqm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = (state == tsqm_pkg::ST_IDLE);
    case (state)
      tsqm_pkg::ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = tsqm_pkg::ST_DISPATCH;
        end
      end
      tsqm_pkg::ST_DISPATCH: begin
        case (status.kind)
          tsqm_pkg::KIND_ENQUEUE: begin
            if (status.out_free) begin
              cmd.enq    = 1'b1;
              state_next = tsqm_pkg::ST_IDLE;
            end
          end
          tsqm_pkg::KIND_TRANSMIT, tsqm_pkg::KIND_FLUSH: begin
            cmd.prep   = 1'b1;
            state_next = tsqm_pkg::ST_WALK;
          end
          default: begin
            state_next = tsqm_pkg::ST_IDLE;
          end
        endcase
      end
      tsqm_pkg::ST_WALK: begin
        if (status.walk_done) begin
          state_next = tsqm_pkg::ST_TAIL;
        end else if (status.action == tsqm_pkg::ACT_KEEP || status.out_free) begin
          cmd.step = 1'b1;
        end
      end
      tsqm_pkg::ST_TAIL: begin
        if (status.sent) begin
          cmd.finish = 1'b1;
          state_next = tsqm_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.tail_emit = 1'b1;
          cmd.finish    = 1'b1;
          state_next    = tsqm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tsqm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/tsqm_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsqm_dp
// Queue storage, match logic, counters, config and output register.
// ----------------------------------------------------------------------------
module tsqm_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tsqm_pkg::item_t                     item,
  input  wire logic                                cfg_valid,
  input  wire logic [tsqm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tsqm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output tsqm_pkg::result_t                        result,
  input  wire tsqm_pkg::cmd_t                      cmd,
  output tsqm_pkg::status_t                        status
);

  localparam int IW = tsqm_pkg::IDX_W;
  localparam int CW = tsqm_pkg::CNT_W;

  tsqm_pkg::entry_t entries [tsqm_pkg::QUEUE_DEPTH];

  tsqm_pkg::item_t   cur;
  logic [13:0]       now;
  logic [9:0]        tgt_sfn;
  logic [3:0]        tgt_slot;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     kept;
  logic              sent;
  logic              channel_kind;
  logic [13:0]       max_age;
  logic [31:0]       bytes_counter;
  logic [31:0]       pdus_counter;
  tsqm_pkg::result_t result_next;

  tsqm_pkg::entry_t  head;
  tsqm_pkg::entry_t  new_entry;
  tsqm_pkg::act_t    action;
  logic [13:0]       age;
  logic [8:0]        slot_sum;
  logic              full;
  logic              emit;
  logic              out_free;
  logic [31:0]       bytes_next;

  assign head     = entries[idx[IW-1:0]];
  assign full     = (count >= CW'(tsqm_pkg::QUEUE_DEPTH));
  assign out_free = !result_valid || result_ready;
  assign slot_sum = 9'(cur.trans_id[7:0]) + 9'(tsqm_pkg::SLOT_DELTA);
  assign age      = (now < head.arrival) ? (14'(tsqm_pkg::TICK_WRAP) - head.arrival) + now
                                         : now - head.arrival;
  assign bytes_next = bytes_counter + 32'(head.size);

  assign new_entry = '{handle:  cur.sdu_handle,
                       size:    cur.sdu_size,
                       sfn:     cur.sched_sfn,
                       slot:    cur.sched_slot,
                       user:    cur.rnti,
                       arrival: now};

  always_comb begin
    if (sent) begin
      action = tsqm_pkg::ACT_KEEP;
    end else if (cur.kind == tsqm_pkg::KIND_FLUSH) begin
      action = tsqm_pkg::ACT_DROP;
    end else if (channel_kind) begin
      action = (head.sfn == tgt_sfn && head.slot == tgt_slot) ? tsqm_pkg::ACT_SEND
                                                              : tsqm_pkg::ACT_DROP;
    end else if (age > max_age) begin
      action = tsqm_pkg::ACT_DROP;
    end else if (head.user != cur.rnti) begin
      action = tsqm_pkg::ACT_KEEP;
    end else begin
      action = tsqm_pkg::ACT_SEND;
    end
  end

  assign emit = cmd.enq || cmd.tail_emit || (cmd.step && action != tsqm_pkg::ACT_KEEP);

  always_comb begin
    result_next = '0;
    result_next.bytes_sent_total = bytes_counter;
    result_next.pdus_sent_total  = pdus_counter;
    if (cmd.enq) begin
      result_next.result_kind = full ? tsqm_pkg::RK_FULL : tsqm_pkg::RK_OCCUPANCY;
      result_next.out_handle  = cur.sdu_handle;
      result_next.out_size    = cur.sdu_size;
      result_next.out_sfn     = cur.sched_sfn;
      result_next.out_slot    = cur.sched_slot;
      result_next.out_rnti    = cur.rnti;
      result_next.last        = 1'b1;
    end else if (cmd.step) begin
      result_next.out_handle = head.handle;
      result_next.out_size   = head.size;
      result_next.out_sfn    = head.sfn;
      result_next.out_slot   = head.slot;
      result_next.out_rnti   = head.user;
      if (action == tsqm_pkg::ACT_SEND) begin
        result_next.result_kind      = tsqm_pkg::RK_SENT;
        result_next.bytes_sent_total = bytes_next;
        result_next.pdus_sent_total  = pdus_counter + 32'd1;
        result_next.last             = 1'b1;
      end else begin
        result_next.result_kind = tsqm_pkg::RK_DROPPED;
      end
    end else begin
      result_next.result_kind = (cur.kind == tsqm_pkg::KIND_FLUSH) ? tsqm_pkg::RK_FLUSH_DONE
                                                                  : tsqm_pkg::RK_NOT_FOUND;
      result_next.last        = 1'b1;
    end
  end

  // control state, counters, config
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      idx           <= '0;
      kept          <= '0;
      sent          <= 1'b0;
      bytes_counter <= '0;
      pdus_counter  <= '0;
      channel_kind  <= 1'b0;
      max_age       <= 14'(tsqm_pkg::MAX_AGE_RESET);
      result_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tsqm_pkg::CFG_CHANNEL_KIND: channel_kind <= cfg_data[0];
          tsqm_pkg::CFG_MAX_AGE:      max_age      <= cfg_data;
          default: ;
        endcase
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.enq && !full) begin
        count <= count + CW'(1);
      end
      if (cmd.prep) begin
        idx  <= '0;
        kept <= '0;
        sent <= 1'b0;
      end
      if (cmd.step) begin
        idx <= idx + CW'(1);
        if (action == tsqm_pkg::ACT_KEEP) begin
          kept <= kept + CW'(1);
        end
        if (action == tsqm_pkg::ACT_SEND) begin
          sent          <= 1'b1;
          bytes_counter <= bytes_next;
          pdus_counter  <= pdus_counter + 32'd1;
        end
      end
      if (cmd.finish) begin
        count <= kept;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
      now <= tsqm_pkg::norm_tick(item.current_time);
    end
    if (cmd.prep) begin
      tgt_slot <= tsqm_pkg::mod_slots(slot_sum);
      tgt_sfn  <= (slot_sum >= 9'(tsqm_pkg::SLOTS_PER_FRAME)) ? cur.trans_id[17:8] + 10'd1
                                                             : cur.trans_id[17:8];
    end
    if (emit) begin
      result <= result_next;
    end
  end

  // queue storage: append on enqueue, compact kept entries during the walk
  always_ff @(posedge clk) begin
    if (cmd.enq && !full) begin
      entries[count[IW-1:0]] <= new_entry;
    end else if (cmd.step && action == tsqm_pkg::ACT_KEEP) begin
      entries[kept[IW-1:0]] <= head;
    end
  end

  assign status = '{kind:      cur.kind,
                    walk_done: (idx == count),
                    action:    action,
                    sent:      sent,
                    out_free:  out_free};

endmodule
`default_nettype wire

@@ rtl/core/tm_sdu_queue_matcher.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tm_sdu_queue_matcher
// Transparent-mode SDU descriptor queue with transmit-opportunity matching.
// ----------------------------------------------------------------------------
// Holds up to 16 SDU descriptors in arrival order. An enqueue beat stores a
// descriptor and answers with one occupancy report (or a full refusal). A
// transmit beat walks the queue from the head, one entry per clock (an entry
// to drop or send waits while the result side stalls) through a single read
// of the entry register file: in broadcast mode it drops entries until one
// matches the frame/slot target (trans_id slot plus 2, frame carried on slot
// wrap); in dedicated mode it drops entries older than max_age ticks, keeps
// other users' entries in order, and sends the first entry for the asked
// user, bumping the byte and PDU totals. A flush beat drops everything and
// ends with a flush-done beat. One beat is handled at a time, and a beat with
// a result to emit waits while the result side stalls. Results sit in an
// output register, so the next input is taken while the final result waits.
// last marks the final result of each input. Config writes (index 0
// channel_kind, 1 max_age) are always ready and belong in idle periods.
// ----------------------------------------------------------------------------
module tm_sdu_queue_matcher (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input beats
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire tsqm_pkg::item_t                 item,
  // result beats
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output tsqm_pkg::result_t                    result,
  // config writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tsqm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsqm_pkg::CFG_DATA_W-1:0] cfg_data
);

  tsqm_pkg::cmd_t    cmd;
  tsqm_pkg::status_t status;

  // registers take a write every cycle
  assign cfg_ready = 1'b1;

  tsqm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  tsqm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
`default_nettype wire
